>>> sv/arwt_pkg.sv
// arwt_pkg: shared types, codes and the range test for the address range watch table
// used by the watch cells, the region cells and the top level; no dependencies
`default_nettype none

package arwt_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned TagW  = 8;

  // operation codes of an input item; code 7 is unused and only closes
  typedef enum logic [2:0] {
    OP_ADD_WATCH    = 3'd0,
    OP_REMOVE_WATCH = 3'd1,
    OP_CLEAR_WATCH  = 3'd2,
    OP_ADD_REGION   = 3'd3,
    OP_CLEAR_REGION = 3'd4,
    OP_WRITE_ACCESS = 3'd5,
    OP_PROT_QUERY   = 3'd6
  } op_e;

  // status codes of a closing item
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_SPAN = 2'd1,
    STAT_FULL     = 2'd2
  } stat_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_EXEC    = 4'b0010,
    ST_COMPACT = 4'b0100,
    ST_EMIT    = 4'b1000
  } state_e;

  // one watch entry
  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] span;
    logic [TagW-1:0]  tag;
  } arwt_went_t;

  // broadcast control for the watch cell row
  typedef struct packed {
    logic             clear;
    logic             add;
    logic             remove;
    logic             probe;
    logic             compact;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] span;
    logic [TagW-1:0]  tag;
  } arwt_wctl_t;

  // broadcast control for the region cell row
  typedef struct packed {
    logic             clear;
    logic             add;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] span;
  } arwt_rctl_t;

  // true when a lies in [base, base + span)
  function automatic logic arwt_in_range(input logic [AddrW-1:0] a,
                                         input logic [AddrW-1:0] base,
                                         input logic [AddrW-1:0] span);
    logic [AddrW:0] lim;
    lim = {1'b0, base} + {1'b0, span};
    return (a >= base) && ({1'b0, a} < lim);
  endfunction

endpackage

`default_nettype wire

>>> sv/arwt_watch_cell.sv
// arwt_watch_cell: one slot of the watch table with its valid bit and hit flag
// depends on arwt_pkg; entries move one cell toward slot 0 per cycle while compacting
`default_nettype none

module arwt_watch_cell import arwt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  arwt_wctl_t ctl_i,
  input  logic       prev_valid_i,
  input  logic       next_valid_i,
  input  arwt_went_t next_entry_i,
  input  logic       hit_clr_i,
  output logic       valid_o,
  output arwt_went_t entry_o,
  output logic       hit_o
);

  logic       valid_q, valid_d;
  logic       hit_q, hit_d;
  arwt_went_t entry_q, entry_d;
  logic       load_new, take, give, drop;

  // slot actions
  assign load_new = ctl_i.add & prev_valid_i & ~valid_q;
  assign take     = ctl_i.compact & ~valid_q & next_valid_i;
  assign give     = ctl_i.compact & valid_q & ~prev_valid_i;
  assign drop     = ctl_i.remove & valid_q & (entry_q.base == ctl_i.addr);

  // occupancy
  always_comb begin
    valid_d = valid_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (load_new || take) begin
      valid_d = 1'b1;
    end else if (give || drop) begin
      valid_d = 1'b0;
    end
  end

  // entry payload
  always_comb begin
    entry_d = entry_q;
    if (load_new) begin
      entry_d.base = ctl_i.addr;
      entry_d.span = ctl_i.span;
      entry_d.tag  = ctl_i.tag;
    end else if (take) begin
      entry_d = next_entry_i;
    end
  end

  // hit flag, latched on a write access and dropped once reported
  always_comb begin
    hit_d = hit_q;
    if (ctl_i.probe) begin
      hit_d = valid_q & arwt_in_range(ctl_i.addr, entry_q.base, entry_q.span);
    end else if (hit_clr_i) begin
      hit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;
  assign hit_o   = hit_q;

endmodule

`default_nettype wire

>>> sv/arwt_region_cell.sv
// arwt_region_cell: one slot of the protection region table
// depends on arwt_pkg; fills in order behind its left neighbor
`default_nettype none

module arwt_region_cell import arwt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  arwt_rctl_t ctl_i,
  input  logic       prev_valid_i,
  output logic       valid_o,
  output logic       match_o
);

  logic             valid_q, valid_d;
  logic [AddrW-1:0] base_q, span_q;
  logic             load_new;

  assign load_new = ctl_i.add & prev_valid_i & ~valid_q;

  // occupancy
  always_comb begin
    valid_d = valid_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (load_new) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // region bounds
  always_ff @(posedge clk_i) begin
    if (load_new) begin
      base_q <= ctl_i.addr;
      span_q <= ctl_i.span;
    end
  end

  assign valid_o = valid_q;
  assign match_o = valid_q & arwt_in_range(ctl_i.addr, base_q, span_q);

endmodule

`default_nettype wire

>>> sv/address_range_watch_table_core.sv
// address_range_watch_table_core: sequencer, output register and the two cell rows
// depends on arwt_pkg, arwt_watch_cell and arwt_region_cell
//
// Usage: one input item per transfer on in_valid_i/in_ready_o carries an operation
// and its operands. Each item answers with zero or more watch hit items (kind 0)
// followed by one closing item (kind 1, last 1) on out_valid_o/out_ready_i.
// cfg_we_i writes the protection enable bit from cfg_wdata_i with no handshake;
// write it only while the block is idle.
// Sequence: an item is taken in the idle state, acted on by every cell at once in the
// execute state, and its results are loaded into the output register in the emit state.
// On a write access, hits leave the output register one per cycle in table order while
// the receiver takes them. A watch removal first passes the compact state, in which
// surviving entries shift one cell per cycle toward slot 0 to close the gaps. A new item
// is taken only after the closing item of the last one has been loaded.
// in_ready_o is high whenever the sequencer is idle, even while the closing item
// still waits in the output register; a stalled receiver holds that register and
// pauses the sequencer only when the next result needs it.
// Reset empties both tables and the output register and clears protection enable.
`default_nettype none

module address_range_watch_table_core import arwt_pkg::*; #(
  parameter int unsigned WATCH_SLOTS  = 16,
  parameter int unsigned REGION_SLOTS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       operation_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [AddrW-1:0] span_i,
  input  logic [TagW-1:0]  callback_tag_i,
  input  logic [31:0]      old_value_i,
  input  logic [31:0]      new_value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             kind_o,
  output logic [TagW-1:0]  hit_tag_o,
  output logic [AddrW-1:0] hit_address_o,
  output logic [31:0]      prior_value_o,
  output logic [31:0]      later_value_o,
  output logic             is_protected_o,
  output logic [1:0]       status_o,
  output logic             last_o
);

  state_e state_q, state_d;

  // captured item
  logic [2:0]       op_q;
  logic [AddrW-1:0] addr_q, span_q;
  logic [TagW-1:0]  tag_q;
  logic [31:0]      oldv_q, newv_q;

  logic  prot_en_q;
  logic  prot_q, prot_d;
  stat_e status_q, status_d;

  // cell rows
  arwt_wctl_t                   wctl;
  arwt_rctl_t                   rctl;
  logic       [WATCH_SLOTS-1:0] wvalid, whit, first_hit, hit_clr;
  arwt_went_t                   wentry [WATCH_SLOTS];
  logic      [REGION_SLOTS-1:0] rvalid, rmatch;

  logic            in_xfer, exec, span_bad, wfull, rfull, w_settled;
  logic            any_hit, slot_free, emit_hit, emit_close;
  logic [AddrW:0]  span_end;
  logic [TagW-1:0] sel_tag;

  // output register
  logic             out_valid_q;
  logic             kind_q, last_q, oprot_q;
  logic [TagW-1:0]  otag_q;
  logic [AddrW-1:0] oaddr_q;
  logic [31:0]      opv_q, olv_q;
  logic [1:0]       ostat_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign exec       = (state_q == ST_EXEC);

  // capture the item on transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= operation_i;
      addr_q <= addr_i;
      span_q <= span_i;
      tag_q  <= callback_tag_i;
      oldv_q <= old_value_i;
      newv_q <= new_value_i;
    end
  end

  // protection enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prot_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      prot_en_q <= cfg_wdata_i;
    end
  end

  // span check: zero, or base + span carrying out of AddrW bits (this includes a range ending on the last address)
  assign span_end = {1'b0, addr_q} + {1'b0, span_q};
  assign span_bad = (span_q == '0) | span_end[AddrW];
  assign wfull    = wvalid[WATCH_SLOTS-1];
  assign rfull    = rvalid[REGION_SLOTS-1];

  // broadcast controls
  always_comb begin
    wctl.clear   = exec & (op_q == OP_CLEAR_WATCH);
    wctl.add     = exec & (op_q == OP_ADD_WATCH) & ~span_bad & ~wfull;
    wctl.remove  = exec & (op_q == OP_REMOVE_WATCH);
    wctl.probe   = exec & (op_q == OP_WRITE_ACCESS);
    wctl.compact = (state_q == ST_COMPACT);
    wctl.addr    = addr_q;
    wctl.span    = span_q;
    wctl.tag     = tag_q;
    rctl.clear   = exec & (op_q == OP_CLEAR_REGION);
    rctl.add     = exec & (op_q == OP_ADD_REGION) & ~span_bad & ~rfull;
    rctl.addr    = addr_q;
    rctl.span    = span_q;
  end

  // watch cell row
  for (genvar g = 0; g < WATCH_SLOTS; g++) begin : g_watch
    logic       prev_v, next_v;
    arwt_went_t next_e;
    if (g == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = wvalid[g-1];
    end
    if (g == WATCH_SLOTS - 1) begin : g_tail
      assign next_v = 1'b0;
      assign next_e = wentry[g];
    end else begin : g_body
      assign next_v = wvalid[g+1];
      assign next_e = wentry[g+1];
    end
    arwt_watch_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (wctl),
      .prev_valid_i (prev_v),
      .next_valid_i (next_v),
      .next_entry_i (next_e),
      .hit_clr_i    (hit_clr[g]),
      .valid_o      (wvalid[g]),
      .entry_o      (wentry[g]),
      .hit_o        (whit[g])
    );
  end

  // region cell row
  for (genvar g = 0; g < REGION_SLOTS; g++) begin : g_region
    logic prev_v;
    if (g == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = rvalid[g-1];
    end
    arwt_region_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (rctl),
      .prev_valid_i (prev_v),
      .valid_o      (rvalid[g]),
      .match_o      (rmatch[g])
    );
  end

  // compaction is done when no free slot sits below a used one
  always_comb begin
    w_settled = 1'b1;
    for (int i = 0; i < int'(WATCH_SLOTS) - 1; i++) begin
      if (!wvalid[i] && wvalid[i+1]) begin
        w_settled = 1'b0;
      end
    end
  end

  // earliest pending hit and its tag
  always_comb begin
    logic seen;
    seen    = 1'b0;
    sel_tag = '0;
    for (int i = 0; i < int'(WATCH_SLOTS); i++) begin
      first_hit[i] = whit[i] & ~seen;
      seen         = seen | whit[i];
      if (first_hit[i]) begin
        sel_tag = wentry[i].tag;
      end
    end
  end

  assign any_hit    = |whit;
  assign slot_free  = ~out_valid_q | out_ready_i;
  assign emit_hit   = (state_q == ST_EMIT) & slot_free & any_hit;
  assign emit_close = (state_q == ST_EMIT) & slot_free & ~any_hit;
  assign hit_clr    = first_hit & {WATCH_SLOTS{emit_hit}};

  // closing answer, settled in the execute cycle
  always_comb begin
    prot_d   = prot_q;
    status_d = status_q;
    if (exec) begin
      prot_d   = (op_q == OP_PROT_QUERY) & prot_en_q & (|rmatch);
      status_d = STAT_OK;
      if (op_q == OP_ADD_WATCH) begin
        if (span_bad) begin
          status_d = STAT_BAD_SPAN;
        end else if (wfull) begin
          status_d = STAT_FULL;
        end
      end else if (op_q == OP_ADD_REGION) begin
        if (span_bad) begin
          status_d = STAT_BAD_SPAN;
        end else if (rfull) begin
          status_d = STAT_FULL;
        end
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = (op_q == OP_REMOVE_WATCH) ? ST_COMPACT : ST_EMIT;
      end
      ST_COMPACT: begin
        if (w_settled) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_close) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prot_q      <= 1'b0;
      status_q    <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      prot_q   <= prot_d;
      status_q <= status_d;
      if (emit_hit || emit_close) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (emit_hit) begin
      kind_q  <= 1'b0;
      otag_q  <= sel_tag;
      oaddr_q <= addr_q;
      opv_q   <= oldv_q;
      olv_q   <= newv_q;
      oprot_q <= 1'b0;
      ostat_q <= STAT_OK;
      last_q  <= 1'b0;
    end else if (emit_close) begin
      kind_q  <= 1'b1;
      otag_q  <= '0;
      oaddr_q <= '0;
      opv_q   <= '0;
      olv_q   <= '0;
      oprot_q <= prot_q;
      ostat_q <= status_q;
      last_q  <= 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign hit_tag_o      = otag_q;
  assign hit_address_o  = oaddr_q;
  assign prior_value_o  = opv_q;
  assign later_value_o  = olv_q;
  assign is_protected_o = oprot_q;
  assign status_o       = ostat_q;
  assign last_o         = last_q;

`ifndef SYNTHESIS
  // watch entries are packed from slot 0 whenever a new item may arrive
  a_watch_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ((wvalid & (wvalid + 1'b1)) == '0))
    else $error("watch table not compacted while idle");

  // region entries are always packed from slot 0
  a_region_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((rvalid & (rvalid + 1'b1)) == '0))
    else $error("region table has a gap");

  // at most one hit flag is dropped per cycle
  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_clr))
    else $error("more than one hit reported in a cycle");

  // no hit may be pending when a new item is taken
  a_hits_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> !any_hit)
    else $error("stale hit flags at item transfer");

  // a shown result is either a hit or a closing item, never a mix
  a_kind_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == last_o))
    else $error("kind and last disagree");
`endif

endmodule

`default_nettype wire
